[src/pooled_cursor_list_engine_top_assert.svh]
// Assertion macros for the pooled cursor list engine.
// Included by the top level; expects clk and rst in the scope of use.
`ifndef POOLED_CURSOR_LIST_ENGINE_TOP_ASSERT_SVH
`define POOLED_CURSOR_LIST_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication.
`define PCLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pcle_pkg.sv]
// Shared types and constants of the pooled cursor list engine.
// No dependencies; imported by pcle_ring and the top level.
`timescale 1ns / 1ps

package pcle_pkg;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;
  localparam int FIELD_W     = 32;
  localparam int LID_W       = 4;
  localparam int COUNT_W     = 8;

  typedef enum logic [3:0] {
    OP_CREATE  = 4'd0,
    OP_COUNT   = 4'd1,
    OP_FIRST   = 4'd2,
    OP_LAST    = 4'd3,
    OP_NEXT    = 4'd4,
    OP_PREV    = 4'd5,
    OP_CURR    = 4'd6,
    OP_ADD     = 4'd7,
    OP_INSERT  = 4'd8,
    OP_APPEND  = 4'd9,
    OP_PREPEND = 4'd10,
    OP_REMOVE  = 4'd11,
    OP_CONCAT  = 4'd12,
    OP_FREE    = 4'd13,
    OP_TRIM    = 4'd14,
    OP_SEARCH  = 4'd15
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LRD,
    S_EXEC,
    S_VAL,
    S_STEP,
    S_INSP,
    S_LNKA,
    S_LNKX,
    S_LNK2,
    S_LNK3,
    S_UNL,
    S_MRD,
    S_FREE,
    S_SRCH,
    S_CREATE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic pop;
    logic put;
  } ring_ctl_t;

endpackage

[src/pcle_ring.sv]
// Ring free queue of indices that reads as 0..DEPTH-1 after reset.
// Depends on pcle_pkg; head is registered from the entry that front points at.
`timescale 1ns / 1ps

module pcle_ring
  import pcle_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int W     = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ring_ctl_t                    ctl,
  input  logic [W-1:0]                 put_data,
  output logic [W-1:0]                 head,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] front, back;
  logic [CW-1:0] fill;
  logic [W-1:0]  rd, ident;
  logic          hit;
  logic          pop_ok, put_ok;

  assign pop_ok = ctl.pop && (count != '0);
  assign put_ok = ctl.put && (count != CW'(DEPTH));

  // Entries at or past the fill mark were never written and still hold
  // their own index.
  assign head = hit ? rd : ident;

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      count <= CW'(DEPTH);
      fill  <= '0;
    end else begin
      if (pop_ok) begin
        front <= (front == PW'(DEPTH - 1)) ? '0 : front + PW'(1);
      end
      if (put_ok) begin
        back <= (back == PW'(DEPTH - 1)) ? '0 : back + PW'(1);
        if (fill != CW'(DEPTH)) begin
          fill <= fill + CW'(1);
        end
      end
      if (put_ok && !pop_ok) begin
        count <= count + CW'(1);
      end else if (pop_ok && !put_ok) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put_ok) begin
      mem[back] <= put_data;
    end
    rd    <= mem[front];
    hit   <= CW'(front) < fill;
    ident <= W'(front);
  end

endmodule

[src/pooled_cursor_list_engine_top.sv]
// Top level of the pooled cursor list engine: list and node memories, the
// operation sequencer and the output register. Depends on pcle_pkg, pcle_ring.
//
//  channel  | dir | fields (tdata, low bit first)
//  s_*      | in  | op[3:0] list_id[7:4] second_list_id[11:8] item_in[43:12]
//           |     | search_key[75:44]
//  m_*      | out | status[1:0] item_out[33:2] new_list_id[37:34] node_count[45:38]
//
// One operation at a time. An item on a list that is not granted goes straight
// to the result and create pops a handle; other ops read the list record first,
// then concat reads the second list record, and cursor moves, remove, trim
// and the add ops read node memory in turn on the single read port
// of each node memory. Free and search walk the list one node at a time.
// Reset is synchronous and needs no clearing pass; a result waits in the
// output register and the next item is taken while it waits.
`timescale 1ns / 1ps
`include "pooled_cursor_list_engine_top_assert.svh"

module pooled_cursor_list_engine_top
  import pcle_pkg::*;
#(
  parameter int NUM_LISTS  = 16,
  parameter int NUM_NODES  = 128,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // op, list_id, second_list_id, item_in, search_key
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status, item_out, new_list_id, node_count, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int NW  = $clog2(NUM_NODES + 1);
  localparam int AW  = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int LAW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int LCW = $clog2(NUM_LISTS + 1);
  localparam logic [NW-1:0] NIL = NW'(NUM_NODES);

  typedef struct packed {
    logic [NW-1:0] head;
    logic [NW-1:0] tail;
    logic [NW-1:0] cur;
    logic [NW-1:0] len;
    logic          bf;
    logic          by;
  } rec_t;

  localparam rec_t REC_CLEAR = '{head: NIL, tail: NIL, cur: NIL, len: '0,
                                 bf: 1'b0, by: 1'b0};

  function automatic logic [AW-1:0] nix(input logic [NW-1:0] p);
    return p[AW-1:0];
  endfunction

  // Input fields.
  op_t                   in_op;
  logic [LID_W-1:0]      in_lid, in_mid;
  logic [FIELD_W-1:0]    in_item, in_key;

  assign in_op   = op_t'(s_tdata[3:0]);
  assign in_lid  = s_tdata[7:4];
  assign in_mid  = s_tdata[11:8];
  assign in_item = s_tdata[43:12];
  assign in_key  = s_tdata[75:44];

  // Registers.
  state_t                state, state_next;
  op_t                   op_r, op_next;
  logic [LID_W-1:0]      lid_r, lid_next, mid_r, mid_next;
  logic [ITEM_WIDTH-1:0] item_r, item_next, key_r, key_next;
  rec_t                  rec, rec_next;
  logic [NW-1:0]         nn, nn_next, an, an_next, xn, xn_next;
  logic [NW-1:0]         wp, wp_next, kcnt, kcnt_next;
  logic [1:0]            res_status, res_status_next;
  logic [ITEM_WIDTH-1:0] res_item, res_item_next;
  logic [LID_W-1:0]      res_newid, res_newid_next;
  logic                  count_en, count_en_next, wb_en, wb_en_next;
  logic [NUM_LISTS-1:0]  live, live_next;
  logic                  m_tvalid_next;
  logic [OUT_TDATA_W-1:0] m_tdata_next;

  logic [LAW-1:0] lidx, midx;
  assign lidx = LAW'(lid_r);
  assign midx = LAW'(mid_r);

  // Node memories.
  logic [ITEM_WIDTH-1:0] nval_mem [NUM_NODES];
  logic [ITEM_WIDTH-1:0] nval_rd, nval_wd;
  logic [AW-1:0]         nval_ra, nval_wa;
  logic                  nval_we;
  logic [NW-1:0]         nnext_mem [NUM_NODES];
  logic [NW-1:0]         nnext_rd, nnext_wd;
  logic [AW-1:0]         nnext_ra, nnext_wa;
  logic                  nnext_we;
  logic [NW-1:0]         nprev_mem [NUM_NODES];
  logic [NW-1:0]         nprev_rd, nprev_wd;
  logic [AW-1:0]         nprev_ra, nprev_wa;
  logic                  nprev_we;

  // List record memory.
  rec_t                  lmem [NUM_LISTS];
  rec_t                  l_rd, l_wd;
  logic [LAW-1:0]        l_ra, l_wa;
  logic                  l_we;

  // Free queues.
  ring_ctl_t             nd_ctl, fl_ctl;
  logic [AW-1:0]         nd_put_data, nd_head;
  logic [NW-1:0]         nd_count;
  logic [LAW-1:0]        fl_put_data, fl_head;
  logic [LCW-1:0]        fl_count;

  pcle_ring #(.DEPTH(NUM_NODES), .W(AW)) u_node_ring (
    .clk      (clk),
    .rst      (rst),
    .ctl      (nd_ctl),
    .put_data (nd_put_data),
    .head     (nd_head),
    .count    (nd_count)
  );

  pcle_ring #(.DEPTH(NUM_LISTS), .W(LAW)) u_list_ring (
    .clk      (clk),
    .rst      (rst),
    .ctl      (fl_ctl),
    .put_data (fl_put_data),
    .head     (fl_head),
    .count    (fl_count)
  );

  assign s_tready = (state == S_IDLE);

  always_comb begin
    logic [NW-1:0] tgt;
    logic [NW-1:0] p_lnk;
    logic [NW-1:0] x_lnk;
    logic [NW-1:0] newlen;
    rec_t          mrec;

    tgt    = '0;
    p_lnk  = '0;
    x_lnk  = '0;
    newlen = '0;
    mrec   = l_rd;

    state_next      = state;
    op_next         = op_r;
    lid_next        = lid_r;
    mid_next        = mid_r;
    item_next       = item_r;
    key_next        = key_r;
    rec_next        = rec;
    nn_next         = nn;
    an_next         = an;
    xn_next         = xn;
    wp_next         = wp;
    kcnt_next       = kcnt;
    res_status_next = res_status;
    res_item_next   = res_item;
    res_newid_next  = res_newid;
    count_en_next   = count_en;
    wb_en_next      = wb_en;
    live_next       = live;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;

    nval_we  = 1'b0;  nval_wa  = '0;  nval_wd  = '0;  nval_ra  = '0;
    nnext_we = 1'b0;  nnext_wa = '0;  nnext_wd = '0;  nnext_ra = '0;
    nprev_we = 1'b0;  nprev_wa = '0;  nprev_wd = '0;  nprev_ra = '0;
    l_we     = 1'b0;  l_wa     = '0;  l_wd     = REC_CLEAR;
    l_ra     = lidx;
    nd_ctl   = '0;    nd_put_data = '0;
    fl_ctl   = '0;    fl_put_data = '0;

    unique case (state)
      S_IDLE: begin
        l_ra = LAW'(in_lid);
        if (s_tvalid) begin
          op_next         = in_op;
          lid_next        = in_lid;
          mid_next        = in_mid;
          item_next       = ITEM_WIDTH'(in_item);
          key_next        = ITEM_WIDTH'(in_key);
          res_status_next = ST_NULL;
          res_item_next   = '0;
          res_newid_next  = '0;
          count_en_next   = 1'b0;
          wb_en_next      = 1'b0;
          if (in_op == OP_CREATE) begin
            state_next = S_CREATE;
          end else if ((32'(in_lid) < NUM_LISTS) && live[LAW'(in_lid)]) begin
            count_en_next = 1'b1;
            wb_en_next    = 1'b1;
            state_next    = S_LRD;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_LRD: begin
        rec_next   = l_rd;
        state_next = S_EXEC;
      end

      S_EXEC: begin
        state_next = S_DONE;
        unique case (op_r)
          OP_CREATE, OP_COUNT: begin
            res_status_next = ST_OK;
          end
          OP_FIRST, OP_LAST: begin
            if (rec.len == '0) begin
              rec_next.cur = NIL;
            end else begin
              tgt = (op_r == OP_FIRST) ? rec.head : rec.tail;
              rec_next.cur = tgt;
              rec_next.bf  = 1'b0;
              rec_next.by  = 1'b0;
              if (tgt == NIL) begin
                res_status_next = ST_OK;
              end else begin
                nval_ra    = nix(tgt);
                state_next = S_VAL;
              end
            end
          end
          OP_NEXT, OP_PREV: begin
            if (rec.len != '0) begin
              // Stepping back in from the far side lands on the cursor node.
              if ((op_r == OP_NEXT) ? rec.bf : rec.by) begin
                rec_next.bf = (op_r == OP_NEXT) ? 1'b0 : rec.bf;
                rec_next.by = (op_r == OP_NEXT) ? rec.by : 1'b0;
                if (rec.cur == NIL) begin
                  res_status_next = ST_OK;
                end else begin
                  nval_ra    = nix(rec.cur);
                  state_next = S_VAL;
                end
              end else if (op_r == OP_NEXT && (rec.by || rec.cur == rec.tail)) begin
                rec_next.by = 1'b1;
              end else if (op_r == OP_PREV && (rec.bf || rec.cur == rec.head)) begin
                rec_next.bf = 1'b1;
              end else if (rec.cur == NIL) begin
                res_status_next = ST_OK;
              end else begin
                nnext_ra   = nix(rec.cur);
                nprev_ra   = nix(rec.cur);
                state_next = S_STEP;
              end
            end
          end
          OP_CURR: begin
            if (rec.len != '0 && !rec.bf && !rec.by) begin
              if (rec.cur == NIL) begin
                res_status_next = ST_OK;
              end else begin
                nval_ra    = nix(rec.cur);
                state_next = S_VAL;
              end
            end
          end
          OP_ADD, OP_INSERT, OP_APPEND, OP_PREPEND: begin
            if (nd_count == '0) begin
              res_status_next = ST_FULL;
            end else begin
              nd_ctl.pop = 1'b1;
              nn_next    = NW'(nd_head);
              state_next = S_LNKA;
              if (op_r == OP_APPEND) begin
                an_next = rec.tail;
              end else if (op_r == OP_PREPEND || rec.len == '0 || rec.bf) begin
                an_next = NIL;
              end else if (rec.by) begin
                an_next = rec.tail;
              end else if (op_r == OP_ADD || rec.cur == NIL) begin
                an_next = (op_r == OP_ADD) ? rec.cur : NIL;
              end else begin
                nprev_ra   = nix(rec.cur);
                state_next = S_INSP;
              end
            end
          end
          OP_REMOVE, OP_TRIM: begin
            tgt = (op_r == OP_TRIM) ? rec.tail : rec.cur;
            if (rec.len != '0 && tgt != NIL &&
                (op_r == OP_TRIM || (!rec.bf && !rec.by))) begin
              nn_next    = tgt;
              nval_ra    = nix(tgt);
              nnext_ra   = nix(tgt);
              nprev_ra   = nix(tgt);
              state_next = S_UNL;
            end
          end
          OP_CONCAT: begin
            if ((32'(mid_r) < NUM_LISTS) && live[midx] && mid_r != lid_r) begin
              l_ra       = midx;
              state_next = S_MRD;
            end
          end
          OP_FREE: begin
            kcnt_next = '0;
            if (rec.len == '0 || rec.head == NIL) begin
              rec_next          = REC_CLEAR;
              live_next[lidx]   = 1'b0;
              fl_ctl.put        = 1'b1;
              fl_put_data       = lidx;
              res_status_next   = ST_OK;
            end else begin
              wp_next    = rec.head;
              nnext_ra   = nix(rec.head);
              state_next = S_FREE;
            end
          end
          OP_SEARCH: begin
            if (rec.len != '0 && !rec.by) begin
              rec_next.bf = 1'b0;
              if (rec.cur == NIL) begin
                rec_next.cur = rec.tail;
                rec_next.by  = 1'b1;
              end else begin
                wp_next    = rec.cur;
                nval_ra    = nix(rec.cur);
                nnext_ra   = nix(rec.cur);
                state_next = S_SRCH;
              end
            end
          end
        endcase
      end

      S_VAL: begin
        res_item_next   = nval_rd;
        res_status_next = ST_OK;
        state_next      = S_DONE;
      end

      S_STEP: begin
        tgt          = (op_r == OP_NEXT) ? nnext_rd : nprev_rd;
        rec_next.cur = tgt;
        if (tgt == NIL) begin
          res_status_next = ST_OK;
          state_next      = S_DONE;
        end else begin
          nval_ra    = nix(tgt);
          state_next = S_VAL;
        end
      end

      S_INSP: begin
        an_next    = nprev_rd;
        state_next = S_LNKA;
      end

      S_LNKA: begin
        if (an == NIL) begin
          xn_next    = rec.head;
          state_next = S_LNK2;
        end else begin
          nnext_ra   = nix(an);
          state_next = S_LNKX;
        end
      end

      S_LNKX: begin
        xn_next    = nnext_rd;
        state_next = S_LNK2;
      end

      S_LNK2: begin
        nval_we  = 1'b1;  nval_wa  = nix(nn);  nval_wd  = item_r;
        nprev_we = 1'b1;  nprev_wa = nix(nn);  nprev_wd = an;
        nnext_we = 1'b1;  nnext_wa = nix(nn);  nnext_wd = xn;
        if (an == NIL) begin
          rec_next.head = nn;
        end
        if (xn == NIL) begin
          rec_next.tail = nn;
        end
        rec_next.len = rec.len + NW'(1);
        rec_next.cur = nn;
        rec_next.bf  = 1'b0;
        rec_next.by  = 1'b0;
        state_next   = S_LNK3;
      end

      S_LNK3: begin
        if (an != NIL) begin
          nnext_we = 1'b1;  nnext_wa = nix(an);  nnext_wd = nn;
        end
        if (xn != NIL) begin
          nprev_we = 1'b1;  nprev_wa = nix(xn);  nprev_wd = nn;
        end
        res_status_next = ST_OK;
        state_next      = S_DONE;
      end

      S_UNL: begin
        p_lnk  = nprev_rd;
        x_lnk  = nnext_rd;
        newlen = (rec.len != '0) ? rec.len - NW'(1) : '0;
        res_item_next   = nval_rd;
        res_status_next = ST_OK;
        if (p_lnk == NIL) begin
          rec_next.head = x_lnk;
        end else begin
          nnext_we = 1'b1;  nnext_wa = nix(p_lnk);  nnext_wd = x_lnk;
        end
        if (x_lnk == NIL) begin
          rec_next.tail = p_lnk;
        end else begin
          nprev_we = 1'b1;  nprev_wa = nix(x_lnk);  nprev_wd = p_lnk;
        end
        rec_next.len = newlen;
        nd_ctl.put   = 1'b1;
        nd_put_data  = nix(nn);
        if (newlen == '0) begin
          rec_next = REC_CLEAR;
        end else if (op_r == OP_TRIM) begin
          rec_next.cur = (x_lnk == NIL) ? p_lnk : rec.tail;
          rec_next.bf  = 1'b0;
          rec_next.by  = 1'b0;
        end else if (x_lnk == NIL) begin
          // Removed the last node: park beyond the new last node.
          rec_next.cur = p_lnk;
          rec_next.by  = 1'b1;
        end else begin
          rec_next.cur = x_lnk;
        end
        state_next = S_DONE;
      end

      S_MRD: begin
        if (mrec.len != '0) begin
          if (rec.len == '0) begin
            rec_next = '{head: mrec.head, tail: mrec.tail, cur: mrec.head,
                         len: mrec.len, bf: 1'b1, by: 1'b0};
          end else begin
            if (rec.tail != NIL) begin
              nnext_we = 1'b1;  nnext_wa = nix(rec.tail);  nnext_wd = mrec.head;
            end
            if (mrec.head != NIL) begin
              nprev_we = 1'b1;  nprev_wa = nix(mrec.head);  nprev_wd = rec.tail;
            end
            rec_next.tail = mrec.tail;
            rec_next.len  = rec.len + mrec.len;
            if (rec.by) begin
              rec_next.cur = mrec.tail;
            end
          end
        end
        live_next[midx] = 1'b0;
        fl_ctl.put      = 1'b1;
        fl_put_data     = midx;
        res_status_next = ST_OK;
        state_next      = S_DONE;
      end

      S_FREE: begin
        // The next link of the node being released arrives this cycle.
        x_lnk       = nnext_rd;
        nd_ctl.put  = 1'b1;
        nd_put_data = nix(wp);
        if ((kcnt + NW'(1)) < rec.len && x_lnk != NIL) begin
          wp_next   = x_lnk;
          kcnt_next = kcnt + NW'(1);
          nnext_ra  = nix(x_lnk);
        end else begin
          rec_next        = REC_CLEAR;
          live_next[lidx] = 1'b0;
          fl_ctl.put      = 1'b1;
          fl_put_data     = lidx;
          res_status_next = ST_OK;
          state_next      = S_DONE;
        end
      end

      S_SRCH: begin
        rec_next.cur = wp;
        if (nval_rd == key_r) begin
          res_item_next   = nval_rd;
          res_status_next = ST_OK;
          state_next      = S_DONE;
        end else if (wp == rec.tail || nnext_rd == NIL) begin
          rec_next.cur = rec.tail;
          rec_next.by  = 1'b1;
          state_next   = S_DONE;
        end else begin
          wp_next  = nnext_rd;
          nval_ra  = nix(nnext_rd);
          nnext_ra = nix(nnext_rd);
        end
      end

      S_CREATE: begin
        if (fl_count == '0) begin
          res_status_next = ST_FULL;
        end else begin
          fl_ctl.pop         = 1'b1;
          l_we               = 1'b1;
          l_wa               = fl_head;
          l_wd               = REC_CLEAR;
          live_next[fl_head] = 1'b1;
          res_newid_next     = LID_W'(fl_head);
          res_status_next    = ST_OK;
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {2'b00,
                           count_en ? COUNT_W'(rec.len) : COUNT_W'(0),
                           res_newid,
                           FIELD_W'(res_item),
                           res_status};
          if (wb_en) begin
            l_we = 1'b1;
            l_wa = lidx;
            l_wd = rec;
          end
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      live     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      live     <= live_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_next;
    lid_r      <= lid_next;
    mid_r      <= mid_next;
    item_r     <= item_next;
    key_r      <= key_next;
    rec        <= rec_next;
    nn         <= nn_next;
    an         <= an_next;
    xn         <= xn_next;
    wp         <= wp_next;
    kcnt       <= kcnt_next;
    res_status <= res_status_next;
    res_item   <= res_item_next;
    res_newid  <= res_newid_next;
    count_en   <= count_en_next;
    wb_en      <= wb_en_next;
    m_tdata    <= m_tdata_next;
  end

  always_ff @(posedge clk) begin
    if (nval_we) begin
      nval_mem[nval_wa] <= nval_wd;
    end
    nval_rd <= nval_mem[nval_ra];
  end

  always_ff @(posedge clk) begin
    if (nnext_we) begin
      nnext_mem[nnext_wa] <= nnext_wd;
    end
    nnext_rd <= nnext_mem[nnext_ra];
  end

  always_ff @(posedge clk) begin
    if (nprev_we) begin
      nprev_mem[nprev_wa] <= nprev_wd;
    end
    nprev_rd <= nprev_mem[nprev_ra];
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      lmem[l_wa] <= l_wd;
    end
    l_rd <= lmem[l_ra];
  end

  `PCLE_ASSERT_NXT(a_accept_leaves_idle, s_tvalid && s_tready, state != S_IDLE, "accepted item did not start")
  `PCLE_ASSERT_NXT(a_done_loads_output, state == S_DONE && (!m_tvalid || m_tready), m_tvalid && state == S_IDLE, "result not loaded")
  `PCLE_ASSERT_IMP(a_free_walk_bound, state == S_FREE, kcnt < rec.len, "free walk ran past list length")
  `PCLE_ASSERT_IMP(a_grant_not_live, state == S_CREATE && fl_count != '0, !live[fl_head], "granted list handle already live")

endmodule
